FILE: rtl/core/fclt_pkg.sv
// shared types, constants and helpers of the film cadence lock tracker
`default_nettype none

package fclt_pkg;

    localparam int DIFF_FRAC_BITS_DEF = 16;

    localparam int GATE_W  = 10;
    localparam int GAIN_W  = 16;
    localparam int SCORE_W = 5;
    localparam int MISS_W  = 2;
    localparam int HYP_W   = 3;
    localparam int NUM_HYP = 5;
    localparam int CFG_W   = 16;
    localparam int CFG_IDX_W = 3;

    localparam logic [GAIN_W-1:0]  CAP_Q16      = 16'd62915;
    localparam logic [SCORE_W-1:0] SCORE_CAP    = 5'd24;
    localparam logic [SCORE_W-1:0] REPEAT_GAIN  = 5'd3;
    localparam logic [SCORE_W-1:0] WEAK_GAIN    = 5'd1;
    localparam logic [SCORE_W-1:0] CONTRA_LOSS  = 5'd4;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LOW_GATE        = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HIGH_GATE       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FLOOR_FALL      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FLOOR_RISE      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_FLOOR       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_LOCK_THRESHOLD  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_LOCK_LEAD       = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_UNLOCK_THRESHOLD = 3'd7;

    localparam logic [GATE_W-1:0]  RST_LOW_GATE         = 10'd358;
    localparam logic [GATE_W-1:0]  RST_HIGH_GATE        = 10'd512;
    localparam logic [GAIN_W-1:0]  RST_FLOOR_FALL       = 16'd19661;
    localparam logic [GAIN_W-1:0]  RST_FLOOR_RISE       = 16'd1311;
    localparam logic [GAIN_W-1:0]  RST_MIN_FLOOR        = 16'd131;
    localparam logic [SCORE_W-1:0] RST_LOCK_THRESHOLD   = 5'd12;
    localparam logic [SCORE_W-1:0] RST_LOCK_LEAD        = 5'd6;
    localparam logic [SCORE_W-1:0] RST_UNLOCK_THRESHOLD = 5'd6;

    localparam logic [1:0] ACT_ADAPT = 2'd0;
    localparam logic [1:0] ACT_HOLD  = 2'd1;
    localparam logic [1:0] ACT_WEAVE = 2'd2;

    localparam logic [HYP_W-1:0] PH_FIRST_REPEAT  = 3'd1;
    localparam logic [HYP_W-1:0] PH_SECOND_REPEAT = 3'd3;

    typedef enum logic [1:0] {
        LVL_LOW  = 2'd0,
        LVL_AMB  = 2'd1,
        LVL_HIGH = 2'd2
    } t_level;

    typedef enum logic [3:0] {
        S_IDLE,
        S_FLOOR_MUL,
        S_FLOOR_UPD,
        S_CAP,
        S_LOW_MUL,
        S_HIGH_MUL,
        S_CLASS,
        S_SCORE,
        S_UNLOCK,
        S_LOCK,
        S_OUT
    } t_state;

    function automatic logic [HYP_W-1:0] phase_of(input logic [HYP_W-1:0] fm,
                                                  input logic [HYP_W-1:0] h);
        logic [HYP_W:0] sum;
        begin
            sum = {1'b0, fm} + {1'b0, h};
            if (sum >= 4'd5) begin
                phase_of = HYP_W'(sum - 4'd5);
            end else begin
                phase_of = HYP_W'(sum);
            end
        end
    endfunction

    function automatic logic [1:0] act_first(input logic [HYP_W-1:0] ph);
        case (ph)
            3'd0: act_first = ACT_HOLD;
            3'd1: act_first = ACT_WEAVE;
            3'd2: act_first = ACT_WEAVE;
            3'd3: act_first = ACT_WEAVE;
            3'd4: act_first = ACT_HOLD;
            default: act_first = ACT_ADAPT;
        endcase
    endfunction

    function automatic logic [1:0] act_second(input logic [HYP_W-1:0] ph);
        case (ph)
            3'd0: act_second = ACT_WEAVE;
            3'd1: act_second = ACT_HOLD;
            3'd2: act_second = ACT_HOLD;
            3'd3: act_second = ACT_WEAVE;
            3'd4: act_second = ACT_WEAVE;
            default: act_second = ACT_ADAPT;
        endcase
    endfunction

    // new score of one hypothesis at phase ph for the field levels l0, l1
    function automatic logic [SCORE_W-1:0] score_step(input logic [SCORE_W-1:0] s,
                                                      input logic [HYP_W-1:0] ph,
                                                      input t_level l0,
                                                      input t_level l1);
        logic r0, r1, w0, w1, mot, e0, e1;
        logic [SCORE_W:0] up;
        begin
            r0  = (l0 == LVL_LOW) && (l1 == LVL_HIGH);
            r1  = (l1 == LVL_LOW) && (l0 == LVL_HIGH);
            w0  = (l0 == LVL_LOW) && (l1 == LVL_AMB);
            w1  = (l1 == LVL_LOW) && (l0 == LVL_AMB);
            mot = (l0 == LVL_HIGH) && (l1 == LVL_HIGH);
            e0  = (ph == PH_FIRST_REPEAT);
            e1  = (ph == PH_SECOND_REPEAT);
            score_step = s;
            if ((r0 && e0) || (r1 && e1)) begin
                up = {1'b0, s} + {1'b0, REPEAT_GAIN};
                score_step = (up > {1'b0, SCORE_CAP}) ? SCORE_CAP : up[SCORE_W-1:0];
            end else if ((w0 && e0) || (w1 && e1)) begin
                up = {1'b0, s} + {1'b0, WEAK_GAIN};
                score_step = (up > {1'b0, SCORE_CAP}) ? SCORE_CAP : up[SCORE_W-1:0];
            end else if (r0 || r1 || (mot && (e0 || e1))) begin
                score_step = (s > CONTRA_LOSS) ? (s - CONTRA_LOSS) : '0;
            end
        end
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/fclt_in_if.sv
// frame channel into the cadence tracker
`default_nettype none

interface fclt_in_if
    import fclt_pkg::*;
#(
    parameter int DIFF_FRAC_BITS = DIFF_FRAC_BITS_DEF
) ();
    localparam int DW = DIFF_FRAC_BITS + 2;

    logic          valid;
    logic          ready;
    logic [DW-1:0] diff_first;
    logic [DW-1:0] diff_second;
    logic [DW-1:0] noise_hint;
    logic [2:0]    frame_mod_five;

    modport source (output valid, diff_first, diff_second, noise_hint, frame_mod_five,
                    input ready);
    modport sink   (input valid, diff_first, diff_second, noise_hint, frame_mod_five,
                    output ready);
endinterface

`default_nettype wire

FILE: rtl/core/fclt_out_if.sv
// result channel out of the cadence tracker
`default_nettype none

interface fclt_out_if
    import fclt_pkg::*;
#(
    parameter int DIFF_FRAC_BITS = DIFF_FRAC_BITS_DEF
) ();
    localparam int DW = DIFF_FRAC_BITS + 2;

    logic          valid;
    logic          ready;
    logic          is_locked;
    logic [2:0]    cadence_phase;
    logic [1:0]    action_first_field;
    logic [1:0]    action_second_field;
    logic [DW-1:0] floor_level;

    modport source (output valid, is_locked, cadence_phase, action_first_field,
                    action_second_field, floor_level, input ready);
    modport sink   (input valid, is_locked, cadence_phase, action_first_field,
                    action_second_field, floor_level, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/fclt_mul.sv
// shared unsigned multiplier with registered product
`default_nettype none

module fclt_mul
    import fclt_pkg::*;
#(
    parameter int A_WIDTH = DIFF_FRAC_BITS_DEF + 2,
    parameter int B_WIDTH = GAIN_W
) (
    input  wire logic                       i_clk,
    input  wire logic [A_WIDTH-1:0]         i_a,
    input  wire logic [B_WIDTH-1:0]         i_b,
    output logic      [A_WIDTH+B_WIDTH-1:0] o_prod
);
    logic [A_WIDTH+B_WIDTH-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= (A_WIDTH+B_WIDTH)'(i_a) * (A_WIDTH+B_WIDTH)'(i_b);
    end

    assign o_prod = r_prod;
endmodule

`default_nettype wire

FILE: rtl/core/film_cadence_lock_tracker_core.sv
// film cadence lock tracker: 3:2 pulldown detection, lock tracking and field actions
// Each frame transaction is worked through a sequencer around one shared
// multiplier: floor step, hint cap, low gate and high gate products are formed
// one after another, then levels, scores, unlock and lock are settled in turn.
// The next frame is accepted only when the sequencer is back in idle, which
// it reaches in the same cycle as the result is first offered; a stalled
// result holds the sequencer in its last step until the output register
// frees up. The noise floor is seeded from the smaller field difference of
// the first frame after reset. Configuration is written through a plain write
// port while idle, a rule for the user that the block itself does not enforce.
`default_nettype none

module film_cadence_lock_tracker_core
    import fclt_pkg::*;
#(
    parameter int DIFF_FRAC_BITS = DIFF_FRAC_BITS_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    fclt_in_if.sink                   i_in,
    fclt_out_if.source                o_out,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [CFG_W-1:0]     i_cfg_data
);
    localparam int DW = DIFF_FRAC_BITS + 2;
    // floor is kept at least as wide as min_floor
    localparam int FW = (DW > GAIN_W) ? DW : GAIN_W;
    localparam int PW = FW + GAIN_W;

    t_state r_state, n_state;

    logic [DW-1:0] r_d0, n_d0, r_d1, n_d1, r_hint, n_hint, r_m, n_m;
    logic [HYP_W-1:0] r_fm, n_fm;

    logic [FW-1:0]      r_floor, n_floor;
    logic               r_seeded, n_seeded;
    logic [SCORE_W-1:0] r_score [NUM_HYP];
    logic [SCORE_W-1:0] n_score [NUM_HYP];
    logic               r_lock, n_lock;
    logic [HYP_W-1:0]   r_lhyp, n_lhyp;
    logic [MISS_W-1:0]  r_miss, n_miss;

    logic   r_lo0, n_lo0, r_lo1, n_lo1;
    t_level r_lvl0, n_lvl0, r_lvl1, n_lvl1;

    logic [GATE_W-1:0]  r_low_gate, r_high_gate;
    logic [GAIN_W-1:0]  r_floor_fall, r_floor_rise, r_min_floor;
    logic [SCORE_W-1:0] r_lock_threshold, r_lock_lead, r_unlock_threshold;

    logic          r_out_valid, n_out_valid;
    logic          r_o_locked, n_o_locked;
    logic [2:0]    r_o_phase, n_o_phase;
    logic [1:0]    r_o_act0, n_o_act0, r_o_act1, n_o_act1;
    logic [DW-1:0] r_o_floor, n_o_floor;

    logic [FW-1:0]     mul_a;
    logic [GAIN_W-1:0] mul_b;
    logic [PW-1:0]     prod;

    fclt_mul #(
        .A_WIDTH (FW),
        .B_WIDTH (GAIN_W)
    ) u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (prod)
    );

    assign i_in.ready                = (r_state == S_IDLE);
    assign o_out.valid               = r_out_valid;
    assign o_out.is_locked           = r_o_locked;
    assign o_out.cadence_phase       = r_o_phase;
    assign o_out.action_first_field  = r_o_act0;
    assign o_out.action_second_field = r_o_act1;
    assign o_out.floor_level         = r_o_floor;

    always_comb begin
        logic [DW-1:0]      m_in;
        logic [FW-1:0]      m_ext;
        logic [PW:0]        rnd;
        logic [FW-1:0]      step;
        logic [FW-1:0]      fl;
        logic [HYP_W-1:0]   ph;
        t_level             e_lvl;
        logic [SCORE_W-1:0] other;
        logic [SCORE_W-1:0] second;
        logic [HYP_W-1:0]   best;
        logic               broke;

        n_state     = r_state;
        n_d0        = r_d0;
        n_d1        = r_d1;
        n_hint      = r_hint;
        n_m         = r_m;
        n_fm        = r_fm;
        n_floor     = r_floor;
        n_seeded    = r_seeded;
        n_score     = r_score;
        n_lock      = r_lock;
        n_lhyp      = r_lhyp;
        n_miss      = r_miss;
        n_lo0       = r_lo0;
        n_lo1       = r_lo1;
        n_lvl0      = r_lvl0;
        n_lvl1      = r_lvl1;
        n_out_valid = r_out_valid & ~o_out.ready;
        n_o_locked  = r_o_locked;
        n_o_phase   = r_o_phase;
        n_o_act0    = r_o_act0;
        n_o_act1    = r_o_act1;
        n_o_floor   = r_o_floor;
        mul_a       = '0;
        mul_b       = '0;

        m_in   = '0;
        m_ext  = FW'(r_m);
        rnd    = {1'b0, prod} + (PW+1)'(32768);
        step   = rnd[PW-1:GAIN_W];
        fl     = r_floor;
        ph     = '0;
        e_lvl  = LVL_AMB;
        other  = '0;
        second = '0;
        best   = '0;
        broke  = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_d0   = i_in.diff_first;
                    n_d1   = i_in.diff_second;
                    n_hint = i_in.noise_hint;
                    m_in   = (i_in.diff_first < i_in.diff_second) ?
                             i_in.diff_first : i_in.diff_second;
                    n_m    = m_in;
                    n_fm   = (i_in.frame_mod_five >= 3'd5) ?
                             (i_in.frame_mod_five - 3'd5) : i_in.frame_mod_five;
                    n_state = S_FLOOR_MUL;
                end
            end
            S_FLOOR_MUL: begin
                if (m_ext < r_floor) begin
                    mul_a = r_floor - m_ext;
                    mul_b = r_floor_fall;
                end else begin
                    mul_a = m_ext - r_floor;
                    mul_b = r_floor_rise;
                end
                n_state = S_FLOOR_UPD;
            end
            S_FLOOR_UPD: begin
                // rounded step never passes m, so no clamp is needed
                if (!r_seeded) begin
                    n_floor  = m_ext;
                    n_seeded = 1'b1;
                end else if (m_ext < r_floor) begin
                    n_floor = r_floor - step;
                end else begin
                    n_floor = r_floor + step;
                end
                mul_a   = FW'(r_hint);
                mul_b   = CAP_Q16;
                n_state = S_CAP;
            end
            S_CAP: begin
                if ((r_hint != '0) && (fl > step)) begin
                    fl = step;
                end
                if (fl < FW'(r_min_floor)) begin
                    fl = FW'(r_min_floor);
                end
                n_floor = fl;
                n_state = S_LOW_MUL;
            end
            S_LOW_MUL: begin
                mul_a   = r_floor;
                mul_b   = GAIN_W'(r_low_gate);
                n_state = S_HIGH_MUL;
            end
            S_HIGH_MUL: begin
                mul_a   = r_floor;
                mul_b   = GAIN_W'(r_high_gate);
                n_lo0   = PW'({r_d0, 8'h00}) < prod;
                n_lo1   = PW'({r_d1, 8'h00}) < prod;
                n_state = S_CLASS;
            end
            S_CLASS: begin
                // low test wins when the gates are out of order
                if (r_lo0) begin
                    n_lvl0 = LVL_LOW;
                end else if (PW'({r_d0, 8'h00}) > prod) begin
                    n_lvl0 = LVL_HIGH;
                end else begin
                    n_lvl0 = LVL_AMB;
                end
                if (r_lo1) begin
                    n_lvl1 = LVL_LOW;
                end else if (PW'({r_d1, 8'h00}) > prod) begin
                    n_lvl1 = LVL_HIGH;
                end else begin
                    n_lvl1 = LVL_AMB;
                end
                n_state = S_SCORE;
            end
            S_SCORE: begin
                if (r_lock) begin
                    ph = phase_of(r_fm, r_lhyp);
                    if ((ph == PH_FIRST_REPEAT) || (ph == PH_SECOND_REPEAT)) begin
                        e_lvl = (ph == PH_FIRST_REPEAT) ? r_lvl0 : r_lvl1;
                        if (e_lvl == LVL_HIGH) begin
                            if (r_miss != 2'd3) begin
                                n_miss = r_miss + 2'd1;
                            end
                        end else if (e_lvl == LVL_LOW) begin
                            n_miss = '0;
                        end
                    end
                end
                for (int h = 0; h < NUM_HYP; h++) begin
                    n_score[h] = score_step(r_score[h], phase_of(r_fm, HYP_W'(h)),
                                            r_lvl0, r_lvl1);
                end
                n_state = S_UNLOCK;
            end
            S_UNLOCK: begin
                for (int h = 0; h < NUM_HYP; h++) begin
                    if ((HYP_W'(h) != r_lhyp) && (r_score[h] > other)) begin
                        other = r_score[h];
                    end
                end
                broke = (r_miss >= 2'd2);
                if (r_lock && (broke || (r_score[r_lhyp] < r_unlock_threshold) ||
                               (other > r_score[r_lhyp]))) begin
                    if (broke) begin
                        n_score[r_lhyp] = '0;
                    end
                    n_lock = 1'b0;
                end
                n_state = S_LOCK;
            end
            S_LOCK: begin
                for (int h = 1; h < NUM_HYP; h++) begin
                    if (r_score[h] > r_score[best]) begin
                        best = HYP_W'(h);
                    end
                end
                for (int h = 0; h < NUM_HYP; h++) begin
                    if ((HYP_W'(h) != best) && (r_score[h] > second)) begin
                        second = r_score[h];
                    end
                end
                if (!r_lock && (r_score[best] >= r_lock_threshold) &&
                    ((r_score[best] - second) >= r_lock_lead)) begin
                    n_lock = 1'b1;
                    n_lhyp = best;
                    n_miss = '0;
                end
                n_state = S_OUT;
            end
            S_OUT: begin
                if (!r_out_valid || o_out.ready) begin
                    n_out_valid = 1'b1;
                    n_o_locked  = r_lock;
                    n_o_phase   = '0;
                    n_o_act0    = ACT_ADAPT;
                    n_o_act1    = ACT_ADAPT;
                    n_o_floor   = r_floor[DW-1:0];
                    if (r_lock) begin
                        ph = phase_of(r_fm, r_lhyp);
                        n_o_phase = ph;
                        // a moved repeat field falls back to adaptive on both fields
                        if (!(((ph == PH_FIRST_REPEAT) && (r_lvl0 == LVL_HIGH)) ||
                              ((ph == PH_SECOND_REPEAT) && (r_lvl1 == LVL_HIGH)))) begin
                            n_o_act0 = act_first(ph);
                            n_o_act1 = act_second(ph);
                        end
                    end
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state            <= S_IDLE;
            r_floor            <= '0;
            r_seeded           <= 1'b0;
            r_score            <= '{default: '0};
            r_lock             <= 1'b0;
            r_lhyp             <= '0;
            r_miss             <= '0;
            r_out_valid        <= 1'b0;
            r_low_gate         <= RST_LOW_GATE;
            r_high_gate        <= RST_HIGH_GATE;
            r_floor_fall       <= RST_FLOOR_FALL;
            r_floor_rise       <= RST_FLOOR_RISE;
            r_min_floor        <= RST_MIN_FLOOR;
            r_lock_threshold   <= RST_LOCK_THRESHOLD;
            r_lock_lead        <= RST_LOCK_LEAD;
            r_unlock_threshold <= RST_UNLOCK_THRESHOLD;
        end else begin
            r_state     <= n_state;
            r_floor     <= n_floor;
            r_seeded    <= n_seeded;
            r_score     <= n_score;
            r_lock      <= n_lock;
            r_lhyp      <= n_lhyp;
            r_miss      <= n_miss;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_LOW_GATE:         r_low_gate         <= i_cfg_data[GATE_W-1:0];
                    CFG_HIGH_GATE:        r_high_gate        <= i_cfg_data[GATE_W-1:0];
                    CFG_FLOOR_FALL:       r_floor_fall       <= i_cfg_data[GAIN_W-1:0];
                    CFG_FLOOR_RISE:       r_floor_rise       <= i_cfg_data[GAIN_W-1:0];
                    CFG_MIN_FLOOR:        r_min_floor        <= i_cfg_data[GAIN_W-1:0];
                    CFG_LOCK_THRESHOLD:   r_lock_threshold   <= i_cfg_data[SCORE_W-1:0];
                    CFG_LOCK_LEAD:        r_lock_lead        <= i_cfg_data[SCORE_W-1:0];
                    CFG_UNLOCK_THRESHOLD: r_unlock_threshold <= i_cfg_data[SCORE_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_d0       <= n_d0;
        r_d1       <= n_d1;
        r_hint     <= n_hint;
        r_m        <= n_m;
        r_fm       <= n_fm;
        r_lo0      <= n_lo0;
        r_lo1      <= n_lo1;
        r_lvl0     <= n_lvl0;
        r_lvl1     <= n_lvl1;
        r_o_locked <= n_o_locked;
        r_o_phase  <= n_o_phase;
        r_o_act0   <= n_o_act0;
        r_o_act1   <= n_o_act1;
        r_o_floor  <= n_o_floor;
    end
endmodule

`default_nettype wire
